@@ src/bbft_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants of the binary box filter with threshold.
// Depends on nothing; every module of the block imports it.
package bbft_pkg;

    // Field and register widths.
    localparam int PIX_W     = 8;
    localparam int DIM_W     = 13;
    localparam int WIN_W     = 5;
    localparam int THR_W     = 8;
    localparam int POS_W     = 12;
    localparam int SLOT_W    = 5;
    localparam int COLSUM_W  = 13;
    localparam int SUM_W     = 18;
    localparam int CFG_IDX_W = 3;

    // Largest frame height and the value of a pixel that is on.
    localparam logic [DIM_W-1:0] MAX_HEIGHT = 13'd4096;
    localparam logic [PIX_W-1:0] PIX_ON     = 8'd255;
    localparam logic [PIX_W-1:0] PIX_OFF    = 8'd0;

    // Register values after reset.
    localparam logic [DIM_W-1:0] RST_IMG_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RST_IMG_HEIGHT = 13'd480;
    localparam logic [WIN_W-1:0] RST_WIN_COLS   = 5'd3;
    localparam logic [WIN_W-1:0] RST_WIN_ROWS   = 5'd3;
    localparam logic [THR_W-1:0] RST_THRESHOLD  = 8'd128;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMG_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_COLS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WIN_ROWS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd4;

    // Sequencer that rebuilds the line store slot after a window height change.
    typedef enum logic [1:0] {
        SLOT_RUN,
        SLOT_MOD,
        SLOT_FOLD
    } slot_fsm_t;

endpackage

@@ src/binary_box_filter_threshold_top.sv @@
`timescale 1ns / 1ps
// Binary box filter with threshold: line store, column sum memory and running window sum.
// Depends on bbft_pkg for widths, register indexes and the sequencer state type.
//
// Usage. Pixels enter in raster order on the pixel channel (pix_valid, pix_stall, pixel),
// one transaction per pixel. For every pixel whose window lies wholly inside the image a
// result transaction leaves on the result channel (res_valid, res_stall) carrying the
// thresholded value, the column and row of the window centre, and frame_last on the
// result caused by the last pixel of a frame. Border pixels give no result.
// Throughput is one pixel per cycle unless pix_stall holds the channel: the column sum memory
// is read when a pixel is taken and written back when it leaves stage 1, with the written sum
// forwarded when the next pixel hits the same column (an image one pixel wide). A result
// passes through stage 1 and stage 2 into the result register before it shows on the result
// port. When the receiver stalls, the result register holds, the two stages behind it fill,
// and pix_stall rises once they are full.
// Configuration transactions (cfg_valid, cfg_ready, cfg_index, cfg_data) are always taken.
// A write of the window height makes the block rebuild its line store slot from the row
// position, one row bit per cycle, and then fold the slot into the line store depth; the
// pixel channel stalls until the rebuild is done.
// Reset clears the position to column 0, row 0 and loads the default registers. The line
// store is not cleared; column sums never written since reset read as zero.
module binary_box_filter_threshold_top
    import bbft_pkg::*;
#(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_WIN   = 31
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 pix_valid,
    output logic                 pix_stall,
    input  logic [PIX_W-1:0]     pixel,

    output logic                 res_valid,
    input  logic                 res_stall,
    output logic [PIX_W-1:0]     out_value,
    output logic [POS_W-1:0]     out_col,
    output logic [POS_W-1:0]     out_row,
    output logic                 frame_last,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    // Column index, and a width that holds any image width and any register value.
    localparam int CW       = $clog2(MAX_WIDTH);
    localparam int WCNT     = $clog2(MAX_WIDTH + 1);
    localparam int SW       = (WCNT > DIM_W) ? WCNT : DIM_W;
    // Ring of recent column sums.
    localparam int RD       = MAX_WIN + 1;
    localparam int KW       = $clog2(RD);
    localparam int WIN_MAX  = (1 << WIN_W) - 1;
    localparam int WC_STEPS = WIN_MAX / RD + 1;
    // Line store.
    localparam int MSW      = $clog2(MAX_WIN);
    localparam int FW       = (MSW > SLOT_W) ? MSW : SLOT_W;
    localparam int RS_DEPTH = MAX_WIN * MAX_WIDTH;
    localparam int AW       = $clog2(RS_DEPTH);
    localparam int BCW      = $clog2(POS_W);

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [KW-1:0] fold_wc(input logic [WIN_W-1:0] v);
        logic [WIN_W+KW-1:0] acc;
        acc = (WIN_W + KW)'(v);
        for (int i = 0; i < WC_STEPS; i++) begin
            if (acc >= (WIN_W + KW)'(RD)) begin
                acc = acc - (WIN_W + KW)'(RD);
            end
        end
        return acc[KW-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] slot,
                                                    input logic [WIN_W-1:0]  wr,
                                                    input logic              clr,
                                                    input logic              inc);
        logic [SLOT_W:0] s1;
        s1 = {1'b0, slot} + 1'b1;
        if (clr) begin
            return '0;
        end
        if (inc) begin
            return (s1 >= {1'b0, wr}) ? '0 : s1[SLOT_W-1:0];
        end
        return slot;
    endfunction

    function automatic logic [MSW-1:0] next_mslot(input logic [SLOT_W-1:0] slot,
                                                  input logic [MSW-1:0]    mslot,
                                                  input logic [WIN_W-1:0]  wr,
                                                  input logic              clr,
                                                  input logic              inc);
        logic [SLOT_W:0] s1;
        logic [MSW:0]    m1;
        s1 = {1'b0, slot} + 1'b1;
        m1 = {1'b0, mslot} + 1'b1;
        if (clr) begin
            return '0;
        end
        if (inc) begin
            if (s1 >= {1'b0, wr}) begin
                return '0;
            end
            return (m1 >= (MSW + 1)'(MAX_WIN)) ? '0 : m1[MSW-1:0];
        end
        return mslot;
    endfunction

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [DIM_W-1:0] img_width_reg;
    logic [DIM_W-1:0] img_height_reg;
    logic [WIN_W-1:0] win_cols_reg;
    logic [WIN_W-1:0] win_rows_reg;
    logic [THR_W-1:0] threshold_reg;

    logic             cfg_we;
    logic             rows_we;
    logic [SW-1:0]    w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [WIN_W-1:0] wc;
    logic [WIN_W-1:0] wr;
    logic [2*WIN_W-1:0] wcwr;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign rows_we   = cfg_we && (cfg_index == CFG_WIN_ROWS);

    always_comb
    begin
        if (img_width_reg == '0) begin
            w_eff = SW'(1);
        end else if (SW'(img_width_reg) > SW'(MAX_WIDTH)) begin
            w_eff = SW'(MAX_WIDTH);
        end else begin
            w_eff = SW'(img_width_reg);
        end
        if (img_height_reg == '0) begin
            h_eff = DIM_W'(1);
        end else if (img_height_reg > MAX_HEIGHT) begin
            h_eff = MAX_HEIGHT;
        end else begin
            h_eff = img_height_reg;
        end
    end

    assign wc   = win_cols_reg | WIN_W'(1);
    assign wr   = win_rows_reg | WIN_W'(1);
    assign wcwr = (2 * WIN_W)'(wc) * (2 * WIN_W)'(wr);

    // ------------------------------------------------------------------
    // Declarations of state
    // ------------------------------------------------------------------
    slot_fsm_t         state_reg;
    slot_fsm_t         state_next;
    logic              mod_busy;
    logic [SLOT_W-1:0] rem_reg;
    logic [FW-1:0]     fold_reg;
    logic [BCW-1:0]    bit_cnt_reg;

    logic [CW-1:0]     col_pos_reg;
    logic [POS_W-1:0]  row_pos_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [MSW-1:0]    mslot_reg;
    logic [KW-1:0]     rec_pos_reg;
    logic [CW-1:0]     hwm_reg;
    logic              hwm_any_reg;

    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic              res_valid_reg;

    logic              accept;
    logic              s1_adv;
    logic              s2_adv;

    // ------------------------------------------------------------------
    // Slot rebuild sequencer: slot = row % H by restoring remainder, then
    // folded into the line store depth.
    // ------------------------------------------------------------------
    logic [SLOT_W:0]   rem_shift;
    logic [SLOT_W-1:0] rem_next;
    logic              fold_ge;

    assign rem_shift = {rem_reg, row_pos_reg[bit_cnt_reg]};
    assign rem_next  = (rem_shift >= {1'b0, wr}) ? SLOT_W'(rem_shift - {1'b0, wr})
                                                 : rem_shift[SLOT_W-1:0];
    assign fold_ge   = {1'b0, fold_reg} >= (FW + 1)'(MAX_WIN);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SLOT_RUN:
            begin
                if (rows_we) begin
                    state_next = SLOT_MOD;
                end
            end
            SLOT_MOD:
            begin
                if (!rows_we && bit_cnt_reg == '0) begin
                    state_next = SLOT_FOLD;
                end
            end
            SLOT_FOLD:
            begin
                if (rows_we) begin
                    state_next = SLOT_MOD;
                end else if (!fold_ge) begin
                    state_next = SLOT_RUN;
                end
            end
            default:
            begin
                state_next = SLOT_RUN;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            SLOT_RUN: mod_busy = 1'b0;
            default:  mod_busy = 1'b1;
        endcase
    end

    // ------------------------------------------------------------------
    // Position of the pixel being taken and of the next one
    // ------------------------------------------------------------------
    logic              wrap_col;
    logic [DIM_W-1:0]  r_pre;
    logic              row_clr;
    logic [CW-1:0]     c_cur;
    logic [POS_W-1:0]  r_cur;
    logic [SLOT_W-1:0] slot_cur;
    logic [MSW-1:0]    mslot_cur;
    logic [KW-1:0]     k_cur;
    logic [SW-1:0]     c_inc;
    logic [DIM_W-1:0]  r_inc;
    logic              end_col;
    logic              end_row;
    logic [CW-1:0]     col_next;
    logic [POS_W-1:0]  row_next;
    logic [SLOT_W-1:0] slot_next;
    logic [MSW-1:0]    mslot_next;
    logic [KW-1:0]     k_next;
    logic [AW-1:0]     rs_addr;
    logic              emit_cur;
    logic              last_cur;
    logic [POS_W-1:0]  ocol_cur;
    logic [POS_W-1:0]  orow_cur;
    logic              cvalid_cur;

    always_comb
    begin
        // A width or height shrunk since the last pixel wraps the position first.
        wrap_col  = SW'(col_pos_reg) >= w_eff;
        r_pre     = wrap_col ? (DIM_W'(row_pos_reg) + 1'b1) : DIM_W'(row_pos_reg);
        row_clr   = r_pre >= h_eff;
        c_cur     = wrap_col ? '0 : col_pos_reg;
        r_cur     = row_clr ? '0 : r_pre[POS_W-1:0];
        slot_cur  = next_slot(slot_reg, wr, row_clr, wrap_col);
        mslot_cur = next_mslot(slot_reg, mslot_reg, wr, row_clr, wrap_col);
        k_cur     = wrap_col ? '0 : rec_pos_reg;

        c_inc     = SW'(c_cur) + 1'b1;
        r_inc     = DIM_W'(r_cur) + 1'b1;
        end_col   = c_inc >= w_eff;
        end_row   = end_col && (r_inc >= h_eff);
        col_next  = end_col ? '0 : c_inc[CW-1:0];
        if (!end_col) begin
            row_next = r_cur;
        end else if (end_row) begin
            row_next = '0;
        end else begin
            row_next = r_inc[POS_W-1:0];
        end
        slot_next  = next_slot(slot_cur, wr, end_row, end_col && !end_row);
        mslot_next = next_mslot(slot_cur, mslot_cur, wr, end_row, end_col && !end_row);
        if (end_col || (k_cur == KW'(RD - 1))) begin
            k_next = '0;
        end else begin
            k_next = k_cur + 1'b1;
        end

        rs_addr    = AW'(mslot_cur) * AW'(MAX_WIDTH) + AW'(c_cur);
        emit_cur   = (r_inc >= DIM_W'(wr)) && (c_inc >= SW'(wc));
        last_cur   = end_row;
        ocol_cur   = POS_W'(SW'(c_cur) - SW'(wc >> 1));
        orow_cur   = POS_W'(DIM_W'(r_cur) - DIM_W'(wr >> 1));
        cvalid_cur = hwm_any_reg && (c_cur <= hwm_reg);
    end

    // ------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------
    logic s2_emit_reg;

    assign s2_adv    = s2_valid_reg && (!s2_emit_reg || !res_valid_reg || !res_stall);
    assign s1_adv    = s1_valid_reg && (!s2_valid_reg || s2_adv);
    assign pix_stall = mod_busy || (s1_valid_reg && !s1_adv);
    assign accept    = pix_valid && !pix_stall;

    // ------------------------------------------------------------------
    // Stage 1 payload and column sum update
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]    s1_p_reg;
    logic [CW-1:0]       s1_c_reg;
    logic [KW-1:0]       s1_k_reg;
    logic                s1_first_reg;
    logic                s1_sub_reg;
    logic                s1_cvalid_reg;
    logic                s1_fwd_reg;
    logic [COLSUM_W-1:0] s1_fwd_val_reg;
    logic                s1_emit_reg;
    logic                s1_fstart_reg;
    logic                s1_last_reg;
    logic                s1_czero_reg;
    logic                s1_leave_reg;
    logic [POS_W-1:0]    s1_ocol_reg;
    logic [POS_W-1:0]    s1_orow_reg;

    logic [PIX_W-1:0]    old_rd_reg;
    logic [COLSUM_W-1:0] colsum_rd_reg;
    logic [COLSUM_W-1:0] cs_base;
    logic [COLSUM_W-1:0] cs_add;
    logic [COLSUM_W-1:0] cs_new;

    logic [PIX_W-1:0]    rs_mem [RS_DEPTH];
    logic [COLSUM_W-1:0] cs_mem [MAX_WIDTH];

    always_comb
    begin
        if (s1_fwd_reg) begin
            cs_base = s1_fwd_val_reg;
        end else if (s1_cvalid_reg) begin
            cs_base = colsum_rd_reg;
        end else begin
            cs_base = '0;
        end
        cs_add = cs_base + COLSUM_W'(s1_p_reg);
        if (s1_first_reg) begin
            cs_new = COLSUM_W'(s1_p_reg);
        end else if (s1_sub_reg) begin
            cs_new = cs_add - COLSUM_W'(old_rd_reg);
        end else begin
            cs_new = cs_add;
        end
    end

    // Line store: the slot of row r minus H is the slot of row r, read before write.
    always_ff @(posedge clk)
    begin
        if (accept) begin
            old_rd_reg       <= rs_mem[rs_addr];
            rs_mem[rs_addr]  <= pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept) begin
            colsum_rd_reg <= cs_mem[c_cur];
        end
        if (s1_adv) begin
            cs_mem[s1_c_reg] <= cs_new;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: running window sum over the last W column sums
    // ------------------------------------------------------------------
    logic [COLSUM_W-1:0] s2_cs_reg;
    logic [KW-1:0]       s2_k_reg;
    logic                s2_fstart_reg;
    logic                s2_last_reg;
    logic                s2_czero_reg;
    logic                s2_leave_reg;
    logic [POS_W-1:0]    s2_ocol_reg;
    logic [POS_W-1:0]    s2_orow_reg;

    logic [COLSUM_W-1:0] rec_reg [RD];
    logic [KW-1:0]       wcmod_reg;
    logic [SUM_W-1:0]    limit_cfg_reg;
    logic [SUM_W-1:0]    sum_limit_reg;
    logic [SUM_W-1:0]    ws_reg;

    logic [KW:0]         rd_diff;
    logic [KW-1:0]       rd_idx;
    logic [COLSUM_W-1:0] leave;
    logic [SUM_W-1:0]    ws_new;
    logic [SUM_W-1:0]    limit;

    always_comb
    begin
        rd_diff = {1'b0, s2_k_reg} - {1'b0, wcmod_reg};
        if (rd_diff[KW]) begin
            rd_idx = KW'(rd_diff + (KW + 1)'(RD));
        end else begin
            rd_idx = rd_diff[KW-1:0];
        end
        leave  = s2_leave_reg ? rec_reg[rd_idx] : '0;
        ws_new = (s2_czero_reg ? '0 : ws_reg) + SUM_W'(s2_cs_reg) - SUM_W'(leave);
        limit  = s2_fstart_reg ? limit_cfg_reg : sum_limit_reg;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] out_value_reg;
    logic [POS_W-1:0] out_col_reg;
    logic [POS_W-1:0] out_row_reg;
    logic             frame_last_reg;

    assign res_valid  = res_valid_reg;
    assign out_value  = out_value_reg;
    assign out_col    = out_col_reg;
    assign out_row    = out_row_reg;
    assign frame_last = frame_last_reg;

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            img_width_reg  <= RST_IMG_WIDTH;
            img_height_reg <= RST_IMG_HEIGHT;
            win_cols_reg   <= RST_WIN_COLS;
            win_rows_reg   <= RST_WIN_ROWS;
            threshold_reg  <= RST_THRESHOLD;
            state_reg      <= SLOT_RUN;
            rem_reg        <= '0;
            fold_reg       <= '0;
            bit_cnt_reg    <= '0;
            col_pos_reg    <= '0;
            row_pos_reg    <= '0;
            slot_reg       <= '0;
            mslot_reg      <= '0;
            rec_pos_reg    <= '0;
            hwm_reg        <= '0;
            hwm_any_reg    <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_IMG_WIDTH:  img_width_reg  <= cfg_data;
                    CFG_IMG_HEIGHT: img_height_reg <= cfg_data;
                    CFG_WIN_COLS:   win_cols_reg   <= cfg_data[WIN_W-1:0];
                    CFG_WIN_ROWS:   win_rows_reg   <= cfg_data[WIN_W-1:0];
                    CFG_THRESHOLD:  threshold_reg  <= cfg_data[THR_W-1:0];
                    default:        ;
                endcase
            end

            state_reg <= state_next;
            if (rows_we) begin
                rem_reg     <= '0;
                bit_cnt_reg <= BCW'(POS_W - 1);
            end else begin
                case (state_reg)
                    SLOT_MOD:
                    begin
                        rem_reg     <= rem_next;
                        fold_reg    <= FW'(rem_next);
                        bit_cnt_reg <= bit_cnt_reg - 1'b1;
                    end
                    SLOT_FOLD:
                    begin
                        if (fold_ge) begin
                            fold_reg <= fold_reg - FW'(MAX_WIN);
                        end
                    end
                    default: ;
                endcase
            end

            if (accept) begin
                col_pos_reg <= col_next;
                row_pos_reg <= row_next;
                slot_reg    <= slot_next;
                mslot_reg   <= mslot_next;
                rec_pos_reg <= k_next;
            end else if (state_reg == SLOT_FOLD && !fold_ge && !rows_we) begin
                slot_reg  <= rem_reg;
                mslot_reg <= fold_reg[MSW-1:0];
            end

            // Columns are always visited upwards from zero, so the highest one
            // written since reset marks every column sum that holds data.
            if (s1_adv && (!hwm_any_reg || s1_c_reg > hwm_reg)) begin
                hwm_reg     <= s1_c_reg;
                hwm_any_reg <= 1'b1;
            end

            if (accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv) begin
                s2_valid_reg <= 1'b1;
            end else if (s2_adv) begin
                s2_valid_reg <= 1'b0;
            end

            if (s2_adv && s2_emit_reg) begin
                res_valid_reg <= 1'b1;
            end else if (!res_stall) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        wcmod_reg     <= fold_wc(wc);
        limit_cfg_reg <= SUM_W'(threshold_reg) * SUM_W'(wcwr);

        if (accept) begin
            s1_p_reg       <= pixel;
            s1_c_reg       <= c_cur;
            s1_k_reg       <= k_cur;
            s1_first_reg   <= (r_cur == '0);
            s1_sub_reg     <= (DIM_W'(r_cur) >= DIM_W'(wr));
            s1_cvalid_reg  <= cvalid_cur;
            // The item ahead writes this column back on the same edge.
            s1_fwd_reg     <= s1_valid_reg && (s1_c_reg == c_cur);
            s1_fwd_val_reg <= cs_new;
            s1_emit_reg    <= emit_cur;
            s1_fstart_reg  <= (c_cur == '0) && (r_cur == '0);
            s1_last_reg    <= last_cur;
            s1_czero_reg   <= (c_cur == '0);
            s1_leave_reg   <= (SW'(c_cur) >= SW'(wc));
            s1_ocol_reg    <= ocol_cur;
            s1_orow_reg    <= orow_cur;
        end

        if (s1_adv) begin
            s2_cs_reg     <= cs_new;
            s2_k_reg      <= s1_k_reg;
            s2_emit_reg   <= s1_emit_reg;
            s2_fstart_reg <= s1_fstart_reg;
            s2_last_reg   <= s1_last_reg;
            s2_czero_reg  <= s1_czero_reg;
            s2_leave_reg  <= s1_leave_reg;
            s2_ocol_reg   <= s1_ocol_reg;
            s2_orow_reg   <= s1_orow_reg;
        end

        if (s2_adv) begin
            ws_reg            <= ws_new;
            rec_reg[s2_k_reg] <= s2_cs_reg;
            if (s2_fstart_reg) begin
                sum_limit_reg <= limit_cfg_reg;
            end
            if (s2_emit_reg) begin
                out_value_reg  <= (ws_new >= limit) ? PIX_ON : PIX_OFF;
                out_col_reg    <= s2_ocol_reg;
                out_row_reg    <= s2_orow_reg;
                frame_last_reg <= s2_last_reg;
            end
        end
    end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench of the binary box filter with threshold: a directed table, two frames
// under the largest windows and random frames, checked against a filter model kept here and hand-typed results.
// Depends on bbft_pkg and binary_box_filter_threshold_top.
module tb;
    import bbft_pkg::*;

    // Sizes of the block as instantiated; the model mirrors them.
    localparam int LINE_W        = 4096;
    localparam int WIN_MAX       = 31;
    localparam int HIST_D        = WIN_MAX + 1;
    localparam int COL_MASK      = 'h1FFF;
    localparam int SUM_MASK      = 'h3FFFF;
    localparam int POS_MASK      = 'hFFF;
    // Settling time after the last expected result; it covers a result still in flight when
    // nothing more is expected.
    localparam int SETTLE_CYCLES = 6;
    localparam int RANDOM_ITEMS  = 900;

    // One filtered output as it appears on the result channel.
    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } frame_res_t;

    // One row of the directed table: either a register write or a pixel, the latter optionally
    // with a result typed in by hand.
    typedef struct packed {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] idx;
        logic [DIM_W-1:0]     data;
        logic [PIX_W-1:0]     px;
        bit                   typed;
        frame_res_t           want;
    } step_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 pix_valid = 1'b0;
    logic                 pix_stall;
    logic [PIX_W-1:0]     pixel     = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic [PIX_W-1:0]     out_value;
    logic [POS_W-1:0]     out_col;
    logic [POS_W-1:0]     out_row;
    logic                 frame_last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;

    // Idling of the pixel sender and stalling of the result receiver, in percent per cycle.
    int unsigned gap_pct     = 14;
    int unsigned stall_pct   = 71;
    int unsigned fault_count = 0;
    int unsigned items_sent  = 0;

    // Filtered outputs still to come from the block, oldest first.
    frame_res_t  predicted[$];
    frame_res_t  head_res;

    // Shadow copy of the registers and the state of the filter model.
    logic [DIM_W-1:0] img_w_reg = RST_IMG_WIDTH;
    logic [DIM_W-1:0] img_h_reg = RST_IMG_HEIGHT;
    logic [WIN_W-1:0] wcols_reg = RST_WIN_COLS;
    logic [WIN_W-1:0] wrows_reg = RST_WIN_ROWS;
    logic [THR_W-1:0] thr_reg   = RST_THRESHOLD;
    bit [COLSUM_W-1:0] col_total [LINE_W];
    bit [PIX_W-1:0]    line_mem  [WIN_MAX * LINE_W];
    bit [COLSUM_W-1:0] col_hist  [HIST_D];
    int win_total = 0;
    int on_limit  = 0;
    int pos_col   = 0;
    int pos_row   = 0;

    step_t plan[$];
    int    base_items;

    binary_box_filter_threshold_top #(
        .MAX_WIDTH (LINE_W),
        .MAX_WIN   (WIN_MAX)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_valid  (pix_valid),
        .pix_stall  (pix_stall),
        .pixel      (pixel),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .out_value  (out_value),
        .out_col    (out_col),
        .out_row    (out_row),
        .frame_last (frame_last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The receiver stalls at random; the rate is set by the stimulus phase.
    always @(posedge clk)
    begin
        res_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // A frame dimension as the block uses it: zero counts as one, large values are clipped.
    function automatic int eff_size(input logic [DIM_W-1:0] v, input int hi);
        if (v == '0)
            return 1;
        return (int'(v) > hi) ? hi : int'(v);
    endfunction

    // Model of the filter for one accepted pixel. It keeps the column sums over the last H rows
    // with a line store of those rows, and a running sum of the last W column sums along the
    // row. A result comes out once the window is complete.
    task automatic filter_step(input logic [PIX_W-1:0] px, output bit hit,
                               output frame_res_t res);
        int w;
        int h;
        int wc;
        int wr;
        int c;
        int r;
        int slot;
        int old;
        int cs;
        int leave;
        w  = eff_size(img_w_reg, LINE_W);
        h  = eff_size(img_h_reg, int'(MAX_HEIGHT));
        wc = int'({wcols_reg[WIN_W-1:1], 1'b1});
        wr = int'({wrows_reg[WIN_W-1:1], 1'b1});
        // A width or height shrunk mid-frame wraps the position here.
        if (pos_col >= w)
        begin
            pos_col = 0;
            pos_row++;
        end
        if (pos_row >= h)
            pos_row = 0;
        c = pos_col;
        r = pos_row;
        // The limit is only taken up at the start of a frame.
        if (c == 0 && r == 0)
            on_limit = (int'(thr_reg) * wc * wr) & SUM_MASK;
        slot = (r % wr) % WIN_MAX;
        old  = int'(line_mem[slot * LINE_W + c]);
        line_mem[slot * LINE_W + c] = px;
        if (r == 0)
            cs = int'(px);
        else if (r >= wr)
            cs = (int'(col_total[c]) + int'(px) - old) & COL_MASK;
        else
            cs = (int'(col_total[c]) + int'(px)) & COL_MASK;
        col_total[c] = cs[COLSUM_W-1:0];
        if (c == 0)
            win_total = 0;
        leave = (c >= wc) ? int'(col_hist[(c - wc) % HIST_D]) : 0;
        win_total = (win_total + cs - leave) & SUM_MASK;
        col_hist[c % HIST_D] = cs[COLSUM_W-1:0];
        hit       = (r + 1 >= wr) && (c + 1 >= wc);
        res.value = (win_total >= on_limit) ? PIX_ON : PIX_OFF;
        res.col   = POS_W'((c - wc / 2) & POS_MASK);
        res.row   = POS_W'((r - wr / 2) & POS_MASK);
        res.last  = (c + 1 >= w) && (r + 1 >= h);
        pos_col = c + 1;
        if (pos_col >= w)
        begin
            pos_col = 0;
            pos_row = r + 1;
            if (pos_row >= h)
                pos_row = 0;
        end
    endtask

    // Sends one pixel transaction, after a random number of idle cycles, and records what it
    // should produce. A hand-typed result takes the place of the model's when one is given.
    task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed,
                              input frame_res_t want);
        bit         hit;
        frame_res_t got;
        while ($urandom_range(0, 99) < gap_pct)
        begin
            pix_valid <= 1'b0;
            @(posedge clk);
        end
        pix_valid <= 1'b1;
        pixel     <= px;
        do
            @(posedge clk);
        while (pix_stall);
        filter_step(px, hit, got);
        if (typed)
            predicted.push_back(want);
        else if (hit)
            predicted.push_back(got);
        items_sent++;
    endtask

    // Register write; the shadow copy follows at the accepting edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_IMG_WIDTH:  img_w_reg = data;
            CFG_IMG_HEIGHT: img_h_reg = data;
            CFG_WIN_COLS:   wcols_reg = data[WIN_W-1:0];
            CFG_WIN_ROWS:   wrows_reg = data[WIN_W-1:0];
            CFG_THRESHOLD:  thr_reg   = data[THR_W-1:0];
            default:        ;
        endcase
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // The sender holds back until every expected result has arrived and the pipeline has had
    // time to empty; registers are only written after this.
    task automatic wait_idle();
        pix_valid <= 1'b0;
        @(posedge clk);
        while (predicted.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Streams pixels until the model is back at the start of a frame. Style 0 gives grey
    // levels, any other style black and white at the given density. When mid_at is non-zero
    // the threshold and window width are rewritten at that pixel, sometimes with an image width
    // no larger than before.
    task automatic stream_frame(input int style, input int density, input int mid_at);
        int               k;
        logic [DIM_W-1:0] junk;
        logic [PIX_W-1:0] px;
        k = 0;
        do
        begin
            if (mid_at != 0 && k == mid_at)
            begin
                wait_idle();
                junk = DIM_W'($urandom);
                write_reg(CFG_THRESHOLD, {junk[DIM_W-1:THR_W], THR_W'($urandom)});
                write_reg(CFG_WIN_COLS, {junk[DIM_W-1:WIN_W], WIN_W'($urandom_range(0, 7))});
                if ($urandom_range(0, 1) == 1)
                    write_reg(CFG_IMG_WIDTH,
                              DIM_W'($urandom_range(1, eff_size(img_w_reg, LINE_W))));
            end
            if (style == 0)
                px = PIX_W'($urandom_range(0, 255));
            else
                px = ($urandom_range(0, 99) < density) ? PIX_ON : PIX_OFF;
            send_pixel(px, 1'b0, '0);
            k++;
        end
        while (pos_col != 0 || pos_row != 0);
    endtask

    // Directed-table rows: a register write, a pixel left to the model, and a pixel whose
    // result is plain enough to type in.
    function automatic step_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [DIM_W-1:0] data);
        step_t s;
        s        = '0;
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.data   = data;
        return s;
    endfunction

    function automatic step_t pix_row(input logic [PIX_W-1:0] px);
        step_t s;
        s    = '0;
        s.px = px;
        return s;
    endfunction

    function automatic step_t chk_row(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] v,
                                      input int col, input int row, input bit last);
        step_t s;
        s            = '0;
        s.px         = px;
        s.typed      = 1'b1;
        s.want.value = v;
        s.want.col   = POS_W'(col);
        s.want.row   = POS_W'(row);
        s.want.last  = last;
        return s;
    endfunction

    task automatic check_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] seen);
        if (seen !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, seen);
            fault_count++;
        end
    endtask

    // Every result transaction is compared with the oldest outstanding expectation. Outputs
    // are sampled at the clock edge, before the block updates them.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (predicted.size() == 0)
            begin
                $display("%0t ns: result with nothing expected, value %0d col %0d row %0d last %0d",
                         $time, out_value, out_col, out_row, frame_last);
                fault_count++;
            end
            else
            begin
                head_res = predicted.pop_front();
                check_field("out_value", POS_W'(head_res.value), POS_W'(out_value));
                check_field("out_col", head_res.col, out_col);
                check_field("out_row", head_res.row, out_row);
                check_field("frame_last", POS_W'(head_res.last), POS_W'(frame_last));
            end
        end
    end

    initial
    begin
        // Directed table. First a 3 x 3 image of white pixels under the window and threshold
        // left by reset: a single result for the centre, which also ends the frame.
        plan.push_back(cfg_row(CFG_IMG_WIDTH, 13'd3));
        plan.push_back(cfg_row(CFG_IMG_HEIGHT, 13'd3));
        repeat (8) plan.push_back(pix_row(PIX_ON));
        plan.push_back(chk_row(PIX_ON, PIX_ON, 1, 1, 1'b1));
        // Zero sizes count as one: every pixel is a frame of its own and a window of one.
        // At the top threshold only a full white pixel passes, exactly on the limit.
        plan.push_back(cfg_row(CFG_IMG_WIDTH, 13'd0));
        plan.push_back(cfg_row(CFG_IMG_HEIGHT, 13'd0));
        plan.push_back(cfg_row(CFG_WIN_COLS, 13'd0));
        plan.push_back(cfg_row(CFG_WIN_ROWS, 13'd0));
        plan.push_back(cfg_row(CFG_THRESHOLD, 13'd255));
        plan.push_back(chk_row(8'd255, PIX_ON, 0, 0, 1'b1));
        plan.push_back(chk_row(8'd254, PIX_OFF, 0, 0, 1'b1));
        // A zero threshold lets even a black pixel through.
        plan.push_back(cfg_row(CFG_THRESHOLD, 13'd0));
        plan.push_back(chk_row(8'd0, PIX_ON, 0, 0, 1'b1));
        // A window wider than the image gives no result at all.
        plan.push_back(cfg_row(CFG_WIN_COLS, 13'd31));
        plan.push_back(pix_row(8'd170));
        // A single row five wide with a three wide window, left to the model.
        plan.push_back(cfg_row(CFG_IMG_WIDTH, 13'd5));
        plan.push_back(cfg_row(CFG_WIN_COLS, 13'd2));
        plan.push_back(cfg_row(CFG_THRESHOLD, 13'd100));
        plan.push_back(pix_row(8'd255));
        plan.push_back(pix_row(8'd0));
        plan.push_back(pix_row(8'd255));
        plan.push_back(pix_row(8'd85));
        plan.push_back(pix_row(8'd255));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_idle();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
            begin
                send_pixel(plan[i].px, plan[i].typed, plan[i].want);
            end
        end

        // The largest windows. A single long row under the widest window, then a single
        // tall column under the tallest window.
        wait_idle();
        write_reg(CFG_IMG_WIDTH, 13'd400);
        write_reg(CFG_IMG_HEIGHT, 13'd1);
        write_reg(CFG_WIN_COLS, 13'd30);
        write_reg(CFG_WIN_ROWS, 13'd0);
        write_reg(CFG_THRESHOLD, DIM_W'($urandom_range(0, 255)));
        stream_frame(1, 50, 0);
        wait_idle();
        write_reg(CFG_IMG_WIDTH, 13'd0);
        write_reg(CFG_IMG_HEIGHT, 13'd200);
        write_reg(CFG_WIN_COLS, 13'd0);
        write_reg(CFG_WIN_ROWS, 13'd31);
        write_reg(CFG_THRESHOLD, DIM_W'($urandom_range(0, 255)));
        stream_frame(1, 50, 0);

        // Random frames. The first third has a slow receiver, the second a slow sender, the
        // last runs with neither side idling. Each frame starts from an idle block with fresh
        // sizes; the other registers are rewritten most of the time, with junk in the unused
        // upper data bits, and now and then a write goes to an index with no register.
        base_items = items_sent;
        while (items_sent - base_items < RANDOM_ITEMS)
        begin : random_frames
            int               style;
            int               density;
            int               mid_at;
            int               n;
            logic [DIM_W-1:0] junk;
            if (items_sent - base_items < RANDOM_ITEMS / 3)
            begin
                gap_pct   = 14;
                stall_pct = 71;
            end
            else if (items_sent - base_items < 2 * RANDOM_ITEMS / 3)
            begin
                gap_pct   = 71;
                stall_pct = 14;
            end
            else
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            wait_idle();
            junk = DIM_W'($urandom);
            write_reg(CFG_IMG_WIDTH, DIM_W'(($urandom_range(0, 15) == 0) ?
                                            $urandom_range(13, 48) : $urandom_range(0, 12)));
            write_reg(CFG_IMG_HEIGHT, DIM_W'(($urandom_range(0, 15) == 0) ?
                                             $urandom_range(11, 36) : $urandom_range(0, 10)));
            if ($urandom_range(0, 99) < 70)
                write_reg(CFG_WIN_COLS, {junk[DIM_W-1:WIN_W],
                          WIN_W'(($urandom_range(0, 9) == 0) ?
                                 $urandom_range(0, 31) : $urandom_range(0, 6))});
            if ($urandom_range(0, 99) < 70)
                write_reg(CFG_WIN_ROWS, {junk[DIM_W-1:WIN_W],
                          WIN_W'(($urandom_range(0, 9) == 0) ?
                                 $urandom_range(0, 31) : $urandom_range(0, 6))});
            if ($urandom_range(0, 99) < 70)
                write_reg(CFG_THRESHOLD, {junk[DIM_W-1:THR_W], THR_W'($urandom)});
            if ($urandom_range(0, 9) == 0)
                write_reg(CFG_THRESHOLD + CFG_IDX_W'($urandom_range(1, 3)), DIM_W'($urandom));
            style   = $urandom_range(0, 3);
            density = $urandom_range(0, 100);
            n       = eff_size(img_w_reg, LINE_W) * eff_size(img_h_reg, int'(MAX_HEIGHT));
            mid_at  = (n > 1 && $urandom_range(0, 5) == 0) ? $urandom_range(1, n - 1) : 0;
            stream_frame(style, density, mid_at);
        end

        // Drain: everything expected must arrive, and nothing more may follow.
        wait_idle();
        repeat (20) @(posedge clk);
        if (predicted.size() != 0)
        begin
            $display("%0t ns: %0d expected results never arrived", $time, predicted.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: a correct run takes well under a tenth of this.
    initial
    begin
        #6_000_000;
        $display("%0t ns: timeout, %0d results outstanding", $time, predicted.size());
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
